### hdl/c8_pkg.sv
// shared types, codes and constants for the chip-8 core
// no dependencies; imported by c8_ctrl, c8_dpath and chip8_cpu_core
package c8_pkg;

	localparam int MEM_BYTES = 4096;
	localparam int MEM_AW = 12;
	localparam int FB_BYTES = 256;
	localparam int FB_AW = 8;
	localparam int STACK_ENTRIES_DEF = 16;
	localparam int FONT_BYTES = 80;

	// item commands
	localparam logic [1:0] CMD_EXEC = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_MEMWR = 2'd2;
	localparam logic [1:0] CMD_FBRD = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_RET_EMPTY = 3'd1;
	localparam logic [2:0] ST_STACK_FULL = 3'd2;
	localparam logic [2:0] ST_BAD_OP = 3'd3;
	localparam logic [2:0] ST_SELF_JUMP = 3'd4;
	localparam logic [2:0] ST_WAIT_KEY = 3'd5;

	// opcode constants
	localparam logic [11:0] OPC_CLS = 12'h0E0;
	localparam logic [11:0] OPC_RET = 12'h0EE;
	localparam logic [7:0] NN_SKP = 8'h9E;
	localparam logic [7:0] NN_SKNP = 8'hA1;
	localparam logic [7:0] NN_GET_DT = 8'h07;
	localparam logic [7:0] NN_WAIT_KEY = 8'h0A;
	localparam logic [7:0] NN_SET_DT = 8'h15;
	localparam logic [7:0] NN_SET_ST = 8'h18;
	localparam logic [7:0] NN_ADD_I = 8'h1E;
	localparam logic [7:0] NN_FONT = 8'h29;
	localparam logic [7:0] NN_BCD = 8'h33;
	localparam logic [7:0] NN_STORE = 8'h55;
	localparam logic [7:0] NN_LOAD = 8'h65;

	// hex font glyphs, five bytes per digit
	localparam logic [7:0] FONT [0:FONT_BYTES-1] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	// datapath operation issued by the controller each cycle
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LATCH,
		OP_DISPATCH,
		OP_FETCH_LO,
		OP_FETCH_DONE,
		OP_READ_Y,
		OP_READ_V0,
		OP_GOT_V0,
		OP_EXEC,
		OP_RET,
		OP_WRVF,
		OP_DRAW_RD,
		OP_DRAW_L,
		OP_DRAW_R,
		OP_BCD,
		OP_ST_RD,
		OP_ST_WR,
		OP_LD_RD,
		OP_LD_WR,
		OP_OUT
	} c8_op_t;

	// instruction class after decode
	typedef enum logic [2:0] {
		K_FAULT,
		K_SIMPLE,
		K_FLAG,
		K_RET,
		K_DRAW,
		K_BCD,
		K_STORE,
		K_LOAD
	} c8_kind_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic [1:0] cmd;
		c8_kind_t kind;
		logic draw_none;
		logic sh_zero;
		logic last_row;
		logic last_reg;
		logic last_bcd;
		logic clr_done;
	} c8_flags_t;

endpackage

### hdl/chip8_cpu_core.sv
// chip-8 core: after reset a pass loads the font and clears memory, no item taken
// one item at a time; tick, memory write and frame-buffer read go from dispatch to the result;
// an instruction fetches its two opcode bytes and reads vx, vy and v0 in turn over stores
// with one read port each; writing vf or returning adds a state, a sprite goes row by row,
// bcd writes three digits, fx55/fx65 step per register; a waiting result holds the next one
// reset (arst_n low) clears all control state and starts the memory load pass
module chip8_cpu_core #(
	parameter int STACK_ENTRIES = c8_pkg::STACK_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [11:0] address,
	input  logic [7:0]  write_data,
	input  logic [15:0] keys_down,
	input  logic [7:0]  random_byte,
	input  logic        key_event_valid,
	input  logic [3:0]  key_event_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        screen_changed,
	output logic [7:0]  read_data,
	output logic        sound_on,
	output logic [11:0] program_counter_out
);
	import c8_pkg::*;

	c8_op_t op;
	c8_flags_t flags;

	// sequencer
	c8_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.op        (op)
	);

	// storage and execution
	c8_dpath #(
		.STACK_ENTRIES (STACK_ENTRIES)
	) u_dpath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.op                  (op),
		.flags               (flags),
		.command             (command),
		.address             (address),
		.write_data          (write_data),
		.keys_down           (keys_down),
		.random_byte         (random_byte),
		.key_event_valid     (key_event_valid),
		.key_event_code      (key_event_code),
		.status              (status),
		.screen_changed      (screen_changed),
		.read_data           (read_data),
		.sound_on            (sound_on),
		.program_counter_out (program_counter_out)
	);

endmodule

### hdl/c8_ctrl.sv
// controller state machine of the chip-8 core
// depends on c8_pkg; drives c8_dpath through c8_op_t
module c8_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  c8_pkg::c8_flags_t flags,
	output c8_pkg::c8_op_t   op
);
	import c8_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_F2, S_F3, S_R1, S_R2, S_R3, S_EXEC,
		S_RET2, S_WRVF, S_DR1, S_DR2, S_DR3, S_BCD, S_ST1, S_ST2, S_LD1, S_LD2,
		S_DONE
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// operation per state
	always_comb begin
		unique case (state_q)
			S_CLEAR:    op = OP_CLEAR;
			S_IDLE:     op = in_valid ? OP_LATCH : OP_NONE;
			S_DISPATCH: op = OP_DISPATCH;
			S_F2:       op = OP_FETCH_LO;
			S_F3:       op = OP_FETCH_DONE;
			S_R1:       op = OP_READ_Y;
			S_R2:       op = OP_READ_V0;
			S_R3:       op = OP_GOT_V0;
			S_EXEC:     op = OP_EXEC;
			S_RET2:     op = OP_RET;
			S_WRVF:     op = OP_WRVF;
			S_DR1:      op = OP_DRAW_RD;
			S_DR2:      op = OP_DRAW_L;
			S_DR3:      op = OP_DRAW_R;
			S_BCD:      op = OP_BCD;
			S_ST1:      op = OP_ST_RD;
			S_ST2:      op = OP_ST_WR;
			S_LD1:      op = OP_LD_RD;
			S_LD2:      op = OP_LD_WR;
			S_DONE:     op = out_free ? OP_OUT : OP_NONE;
			default:    op = OP_NONE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			// result valid set on a new result, dropped once taken
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: if (flags.clr_done) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_DISPATCH;
				S_DISPATCH: state_q <= (flags.cmd == CMD_EXEC) ? S_F2 : S_DONE;
				S_F2: state_q <= S_F3;
				S_F3: state_q <= S_R1;
				S_R1: state_q <= S_R2;
				S_R2: state_q <= S_R3;
				S_R3: state_q <= S_EXEC;
				S_EXEC: begin
					unique case (flags.kind)
						K_FLAG:  state_q <= S_WRVF;
						K_RET:   state_q <= S_RET2;
						K_DRAW:  state_q <= flags.draw_none ? S_WRVF : S_DR1;
						K_BCD:   state_q <= S_BCD;
						K_STORE: state_q <= S_ST1;
						K_LOAD:  state_q <= S_LD1;
						default: state_q <= S_DONE;
					endcase
				end
				S_RET2: state_q <= S_DONE;
				S_WRVF: state_q <= S_DONE;
				S_DR1: state_q <= S_DR2;
				S_DR2: begin
					if (!flags.sh_zero) state_q <= S_DR3;
					else state_q <= flags.last_row ? S_WRVF : S_DR1;
				end
				S_DR3: state_q <= flags.last_row ? S_WRVF : S_DR1;
				S_BCD: if (flags.last_bcd) state_q <= S_DONE;
				S_ST1: state_q <= S_ST2;
				S_ST2: state_q <= flags.last_reg ? S_DONE : S_ST1;
				S_LD1: state_q <= S_LD2;
				S_LD2: state_q <= flags.last_reg ? S_DONE : S_LD1;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/c8_dpath.sv
// datapath of the chip-8 core: memories, registers, decode and result register
// depends on c8_pkg; sequenced by c8_ctrl
module c8_dpath #(
	parameter int STACK_ENTRIES = c8_pkg::STACK_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  c8_pkg::c8_op_t    op,
	output c8_pkg::c8_flags_t flags,
	input  logic [1:0]        command,
	input  logic [11:0]       address,
	input  logic [7:0]        write_data,
	input  logic [15:0]       keys_down,
	input  logic [7:0]        random_byte,
	input  logic              key_event_valid,
	input  logic [3:0]        key_event_code,
	output logic [2:0]        status,
	output logic              screen_changed,
	output logic [7:0]        read_data,
	output logic              sound_on,
	output logic [11:0]       program_counter_out
);
	import c8_pkg::*;

	localparam int STK_AW = $clog2(STACK_ENTRIES);
	localparam int SP_W = $clog2(STACK_ENTRIES + 1);

	// storage
	logic [7:0] mem [0:MEM_BYTES-1];
	logic [7:0] rf [0:15];
	logic [7:0] fb [0:FB_BYTES-1];
	logic [FB_BYTES-1:0] fb_vld_q;
	logic [11:0] stk [0:STACK_ENTRIES-1];

	// architectural and control registers
	logic [11:0] pc_q, i_q, clr_q;
	logic [SP_W-1:0] sp_q;
	logic [7:0] dt_q, st_q;

	// latched transaction and working registers
	logic [1:0] cmd_q;
	logic [11:0] addr_q;
	logic [7:0] wdata_q, rnd_q;
	logic [15:0] keys_q;
	logic kv_q;
	logic [3:0] kc_q;
	logic [15:0] opc_q;
	logic [7:0] vx_q, vy_q, v0_q, b_q;
	logic [3:0] cnt_q;
	logic flag_q;
	logic [2:0] stat_q;
	logic scr_q;
	logic [7:0] mem_rd_q, rf_rd_q, fb_rd_q;
	logic [11:0] stk_rd_q;

	// field split
	logic [3:0] hi, x, n;
	logic [7:0] nn;
	logic [11:0] nnn, pc_next, pc_skip, i_cnt;
	assign hi = opc_q[15:12];
	assign x = opc_q[11:8];
	assign n = opc_q[3:0];
	assign nn = opc_q[7:0];
	assign nnn = opc_q[11:0];
	assign pc_next = pc_q + 12'd2;
	assign pc_skip = pc_q + 12'd4;
	assign i_cnt = i_q + {8'd0, cnt_q};

	// instruction decode
	c8_kind_t kind;
	logic [2:0] fault;
	logic [11:0] new_pc, i_d;
	logic pc_we, rfw_x, flag_d, i_we, dt_we, st_we, push, fb_clr;
	logic [7:0] rfw_d;
	logic [8:0] sum9;
	logic key_down;
	assign sum9 = {1'b0, vx_q} + {1'b0, vy_q};
	assign key_down = keys_q[vx_q[3:0]];

	always_comb begin
		kind = K_SIMPLE;
		fault = ST_OK;
		new_pc = pc_next;
		pc_we = 1'b1;
		rfw_x = 1'b0;
		rfw_d = 8'd0;
		flag_d = 1'b0;
		i_we = 1'b0;
		i_d = 12'd0;
		dt_we = 1'b0;
		st_we = 1'b0;
		push = 1'b0;
		fb_clr = 1'b0;
		unique case (hi)
			4'h0: begin
				if (nnn == OPC_CLS) fb_clr = 1'b1;
				else if (nnn == OPC_RET) begin
					if (sp_q == '0) fault = ST_RET_EMPTY;
					else begin
						kind = K_RET;
						pc_we = 1'b0;
					end
				end else fault = ST_BAD_OP;
			end
			4'h1: begin
				if (nnn == pc_q) fault = ST_SELF_JUMP;
				new_pc = nnn;
			end
			4'h2: begin
				if (sp_q == SP_W'(STACK_ENTRIES)) fault = ST_STACK_FULL;
				push = 1'b1;
				new_pc = nnn;
			end
			4'h3: new_pc = (vx_q == nn) ? pc_skip : pc_next;
			4'h4: new_pc = (vx_q != nn) ? pc_skip : pc_next;
			4'h5: begin
				if (n != 4'h0) fault = ST_BAD_OP;
				new_pc = (vx_q == vy_q) ? pc_skip : pc_next;
			end
			4'h6: begin
				rfw_x = 1'b1;
				rfw_d = nn;
			end
			4'h7: begin
				rfw_x = 1'b1;
				rfw_d = vx_q + nn;
			end
			4'h8: begin
				rfw_x = 1'b1;
				unique case (n)
					4'h0: rfw_d = vy_q;
					4'h1: rfw_d = vx_q | vy_q;
					4'h2: rfw_d = vx_q & vy_q;
					4'h3: rfw_d = vx_q ^ vy_q;
					4'h4: begin
						rfw_d = sum9[7:0];
						flag_d = sum9[8];
						kind = K_FLAG;
					end
					4'h5: begin
						rfw_d = vx_q - vy_q;
						flag_d = (vx_q >= vy_q);
						kind = K_FLAG;
					end
					4'h6: begin
						rfw_d = {1'b0, vx_q[7:1]};
						flag_d = vx_q[0];
						kind = K_FLAG;
					end
					4'h7: begin
						rfw_d = vy_q - vx_q;
						flag_d = (vy_q >= vx_q);
						kind = K_FLAG;
					end
					4'hE: begin
						rfw_d = {vx_q[6:0], 1'b0};
						flag_d = vx_q[7];
						kind = K_FLAG;
					end
					default: fault = ST_BAD_OP;
				endcase
			end
			4'h9: begin
				if (n != 4'h0) fault = ST_BAD_OP;
				new_pc = (vx_q != vy_q) ? pc_skip : pc_next;
			end
			4'hA: begin
				i_we = 1'b1;
				i_d = nnn;
			end
			4'hB: new_pc = {4'd0, v0_q} + nnn;
			4'hC: begin
				rfw_x = 1'b1;
				rfw_d = rnd_q & nn;
			end
			4'hD: kind = K_DRAW;
			4'hE: begin
				if (nn == NN_SKP) new_pc = key_down ? pc_skip : pc_next;
				else if (nn == NN_SKNP) new_pc = key_down ? pc_next : pc_skip;
				else fault = ST_BAD_OP;
			end
			4'hF: begin
				unique case (nn)
					NN_GET_DT: begin
						rfw_x = 1'b1;
						rfw_d = dt_q;
					end
					NN_WAIT_KEY: begin
						if (!kv_q) fault = ST_WAIT_KEY;
						rfw_x = 1'b1;
						rfw_d = {4'd0, kc_q};
					end
					NN_SET_DT: dt_we = 1'b1;
					NN_SET_ST: st_we = 1'b1;
					NN_ADD_I: begin
						i_we = 1'b1;
						i_d = i_q + {4'd0, vx_q};
					end
					NN_FONT: begin
						i_we = 1'b1;
						i_d = {4'd0, vx_q} + {2'd0, vx_q, 2'd0};
					end
					NN_BCD: kind = K_BCD;
					NN_STORE: kind = K_STORE;
					NN_LOAD: kind = K_LOAD;
					default: fault = ST_BAD_OP;
				endcase
			end
			default: fault = ST_BAD_OP;
		endcase
		if (fault != ST_OK) kind = K_FAULT;
	end

	logic exec_ok;
	assign exec_ok = (op == OP_EXEC) && (fault == ST_OK);

	// sprite geometry
	logic [4:0] row;
	logic [2:0] col, sh;
	logic [FB_AW-1:0] loc, loc2;
	logic [7:0] bits_l, bits_r;
	logic [15:0] wide_r;
	assign row = vy_q[4:0] + {1'b0, cnt_q};
	assign col = vx_q[5:3];
	assign sh = vx_q[2:0];
	assign loc = {row, col};
	assign loc2 = {row, col + 3'd1};
	assign bits_l = mem_rd_q >> sh;
	assign wide_r = {b_q, 8'd0} >> sh;
	assign bits_r = wide_r[7:0];

	// bcd digits
	logic [1:0] hund;
	logic [7:0] rem_h;
	logic [14:0] mul_t;
	logic [3:0] tens, ones;
	logic [7:0] bcd_d;
	always_comb begin
		if (vx_q >= 8'd200) hund = 2'd2;
		else if (vx_q >= 8'd100) hund = 2'd1;
		else hund = 2'd0;
		rem_h = vx_q - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
		mul_t = {7'd0, rem_h} * 15'd205;
		tens = mul_t[14:11];
		ones = rem_h[3:0] - {tens[2:0], 1'b0} - {tens[0], 3'd0};
		unique case (cnt_q[1:0])
			2'd0: bcd_d = {6'd0, hund};
			2'd1: bcd_d = {4'd0, tens};
			default: bcd_d = {4'd0, ones};
		endcase
	end

	// main memory port muxing
	logic [11:0] mem_ra, mem_wa;
	logic mem_we;
	logic [7:0] mem_wd;
	always_comb begin
		mem_ra = i_cnt;
		if (op == OP_DISPATCH) mem_ra = pc_q;
		else if (op == OP_FETCH_LO) mem_ra = pc_q + 12'd1;
		mem_we = 1'b0;
		mem_wa = i_cnt;
		mem_wd = rf_rd_q;
		priority case (op)
			OP_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = (clr_q < 12'(FONT_BYTES)) ? FONT[clr_q[6:0]] : 8'd0;
			end
			OP_DISPATCH: begin
				mem_we = (cmd_q == CMD_MEMWR);
				mem_wa = addr_q;
				mem_wd = wdata_q;
			end
			OP_BCD: begin
				mem_we = 1'b1;
				mem_wd = bcd_d;
			end
			OP_ST_WR: mem_we = 1'b1;
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	// register file port muxing
	logic [3:0] rf_ra, rf_wa;
	logic rf_we;
	logic [7:0] rf_wd;
	always_comb begin
		rf_ra = cnt_q;
		if (op == OP_FETCH_DONE) rf_ra = x;
		else if (op == OP_READ_Y) rf_ra = opc_q[7:4];
		else if (op == OP_READ_V0) rf_ra = 4'd0;
		rf_we = 1'b0;
		rf_wa = x;
		rf_wd = rfw_d;
		priority case (op)
			OP_CLEAR: begin
				rf_we = 1'b1;
				rf_wa = clr_q[3:0];
				rf_wd = 8'd0;
			end
			OP_EXEC: rf_we = exec_ok && rfw_x;
			OP_WRVF: begin
				rf_we = 1'b1;
				rf_wa = 4'hF;
				rf_wd = {7'd0, flag_q};
			end
			OP_LD_WR: begin
				rf_we = 1'b1;
				rf_wa = cnt_q;
				rf_wd = mem_rd_q;
			end
			default: rf_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf[rf_wa] <= rf_wd;
		rf_rd_q <= rf[rf_ra];
	end

	// frame buffer ports
	logic [FB_AW-1:0] fb_ra, fb_wa;
	logic fb_re, fb_we;
	logic [7:0] fb_wd;
	always_comb begin
		fb_re = 1'b1;
		fb_ra = loc;
		fb_we = 1'b0;
		fb_wa = loc;
		fb_wd = fb_rd_q ^ bits_l;
		unique case (op)
			OP_DISPATCH: fb_ra = addr_q[FB_AW-1:0];
			OP_DRAW_RD: fb_ra = loc;
			OP_DRAW_L: begin
				fb_ra = loc2;
				fb_we = 1'b1;
			end
			OP_DRAW_R: begin
				fb_re = 1'b0;
				fb_we = 1'b1;
				fb_wa = loc2;
				fb_wd = fb_rd_q ^ bits_r;
			end
			default: fb_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fb_we) fb[fb_wa] <= fb_wd;
		if (fb_re) fb_rd_q <= fb_vld_q[fb_ra] ? fb[fb_ra] : 8'd0;
	end

	// frame buffer valid bits, cleared as a whole
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_vld_q <= '0;
		end else if (exec_ok && fb_clr) begin
			fb_vld_q <= '0;
		end else if (fb_we) begin
			fb_vld_q[fb_wa] <= 1'b1;
		end
	end

	// return stack
	logic [SP_W-1:0] sp_dec;
	assign sp_dec = sp_q - 1'b1;
	always_ff @(posedge clk) begin
		if (exec_ok && push) stk[sp_q[STK_AW-1:0]] <= pc_next;
		if (exec_ok && kind == K_RET) stk_rd_q <= stk[sp_dec[STK_AW-1:0]];
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 12'h200;
			i_q <= '0;
			sp_q <= '0;
			dt_q <= '0;
			st_q <= '0;
			clr_q <= '0;
		end else begin
			if (op == OP_CLEAR) clr_q <= clr_q + 12'd1;
			if (op == OP_DISPATCH && cmd_q == CMD_TICK) begin
				if (st_q != 8'd0) st_q <= st_q - 8'd1;
				if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
			end
			if (exec_ok) begin
				if (pc_we) pc_q <= new_pc;
				if (i_we) i_q <= i_d;
				if (dt_we) dt_q <= vx_q;
				if (st_we) st_q <= vx_q;
				if (push) sp_q <= sp_q + 1'b1;
				if (kind == K_RET) sp_q <= sp_dec;
			end
			if (op == OP_RET) pc_q <= stk_rd_q;
		end
	end

	// transaction latch and working registers
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LATCH: begin
				cmd_q <= command;
				addr_q <= address;
				wdata_q <= write_data;
				keys_q <= keys_down;
				rnd_q <= random_byte;
				kv_q <= key_event_valid;
				kc_q <= key_event_code;
				stat_q <= ST_OK;
				scr_q <= 1'b0;
			end
			OP_FETCH_LO: opc_q[15:8] <= mem_rd_q;
			OP_FETCH_DONE: opc_q[7:0] <= mem_rd_q;
			OP_READ_Y: vx_q <= rf_rd_q;
			OP_READ_V0: vy_q <= rf_rd_q;
			OP_GOT_V0: v0_q <= rf_rd_q;
			OP_EXEC: begin
				stat_q <= fault;
				scr_q <= (fault == ST_OK) && (fb_clr || kind == K_DRAW);
				flag_q <= flag_d;
				cnt_q <= 4'd0;
			end
			OP_DRAW_L: begin
				b_q <= mem_rd_q;
				flag_q <= flag_q | (|(fb_rd_q & bits_l));
				if (sh == 3'd0) cnt_q <= cnt_q + 4'd1;
			end
			OP_DRAW_R: begin
				flag_q <= flag_q | (|(fb_rd_q & bits_r));
				cnt_q <= cnt_q + 4'd1;
			end
			OP_BCD, OP_ST_WR, OP_LD_WR: cnt_q <= cnt_q + 4'd1;
			default: cnt_q <= cnt_q;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (op == OP_OUT) begin
			status <= stat_q;
			screen_changed <= scr_q;
			read_data <= (cmd_q == CMD_FBRD && addr_q[11:FB_AW] == '0) ? fb_rd_q : 8'd0;
			sound_on <= (st_q != 8'd0);
			program_counter_out <= pc_q;
		end
	end

	// status toward the controller
	assign flags.cmd = cmd_q;
	assign flags.kind = kind;
	assign flags.draw_none = (vx_q[7:6] != 2'd0) || (vy_q[7:5] != 3'd0) || (n == 4'd0);
	assign flags.sh_zero = (sh == 3'd0);
	assign flags.last_row = (cnt_q == n - 4'd1);
	assign flags.last_reg = (cnt_q == x);
	assign flags.last_bcd = (cnt_q == 4'd2);
	assign flags.clr_done = (clr_q == 12'(MEM_BYTES - 1));

endmodule
